// ===== rtl/core/htfd_pkg.sv =====
// Shared constants for the humidity/temperature frame decoder.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package htfd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned RAW_W   = 16;
	localparam int unsigned GAIN_W  = 18;
	localparam int unsigned VALUE_W = 18;
	localparam int unsigned FRAC_W  = 16;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;
	localparam logic [RAW_W-1:0]  RAW_MASK = 16'hFFFC;

	// Scaled constants: gain x1000 (per 65536 raw LSBs), offset x1000 << FRAC_W.
	localparam logic [GAIN_W-1:0] T_GAIN    = 18'd175720;
	localparam logic [GAIN_W-1:0] RH_GAIN   = 18'd125000;
	localparam logic [31:0]       T_OFFSET  = 32'd46850 << FRAC_W;
	localparam logic [31:0]       RH_OFFSET = 32'd6000 << FRAC_W;

	typedef enum logic {
		KIND_TEMP  = 1'b0,
		KIND_HUMID = 1'b1
	} kind_t;

	typedef enum logic {
		ST_OK      = 1'b0,
		ST_CRC_ERR = 1'b1
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/htfd_crc_step.sv =====
// One byte of CRC-8 (polynomial 0x31, MSB first, no final xor).
// Depends on htfd_pkg for the polynomial and byte width.
`default_nettype none

module htfd_crc_step (
	input  wire logic [htfd_pkg::BYTE_W-1:0] crc_in,
	input  wire logic [htfd_pkg::BYTE_W-1:0] data,
	output logic      [htfd_pkg::BYTE_W-1:0] crc_out
);
	import htfd_pkg::*;

	always_comb begin
		logic [BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if ((c & CRC_MSB) != '0) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

// ===== rtl/core/htfd_convert.sv =====
// Raw word to milli-units: one constant multiply, offset subtract and
// truncating divide by 65536. Depends on htfd_pkg.
`default_nettype none

module htfd_convert (
	input  wire logic                              kind,
	input  wire logic [htfd_pkg::RAW_W-1:0]        raw,
	output logic signed [htfd_pkg::VALUE_W-1:0]    value
);
	import htfd_pkg::*;

	localparam int unsigned PROD_W = RAW_W + GAIN_W;
	localparam int unsigned NUM_W  = PROD_W + 2;

	logic [GAIN_W-1:0]       gain;
	logic [31:0]             offset;
	logic [PROD_W-1:0]       prod;
	logic signed [NUM_W-1:0] num;
	logic signed [NUM_W-FRAC_W-1:0] quot;
	logic                    round_up;

	assign gain   = (kind == KIND_HUMID) ? RH_GAIN : T_GAIN;
	assign offset = (kind == KIND_HUMID) ? RH_OFFSET : T_OFFSET;
	assign prod   = PROD_W'(raw) * PROD_W'(gain);
	assign num    = $signed({2'b00, prod}) - $signed(NUM_W'(offset));

	// Arithmetic shift floors; bump negatives with a remainder toward zero.
	assign quot     = num[NUM_W-1:FRAC_W];
	assign round_up = num[NUM_W-1] && (num[FRAC_W-1:0] != '0);
	assign value    = VALUE_W'(quot + (NUM_W-FRAC_W)'(round_up));

endmodule

`default_nettype wire

// ===== rtl/core/humidity_temp_frame_decode.sv =====
// Top level of the humidity/temperature frame decoder: input register,
// CRC check and conversion, result register. Depends on htfd_pkg,
// htfd_crc_step and htfd_convert.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, req_type, data_msb,      | to block
//          | data_lsb, check_byte                         |
//  out     | out_valid, out_ready, status, measured_value | from block
//
// One frame is accepted per cycle while in_ready is high; a result is presented
// on out after it passes the input register, then the result register.
// Both CRC byte steps and the conversion multiply sit between the two
// registers.
// Reset empties both stages. An out stall holds the result register and,
// once full, the input register; in_ready is high while either has room.
`default_nettype none

module humidity_temp_frame_decode (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             req_type,
	input  wire logic [htfd_pkg::BYTE_W-1:0]      data_msb,
	input  wire logic [htfd_pkg::BYTE_W-1:0]      data_lsb,
	input  wire logic [htfd_pkg::BYTE_W-1:0]      check_byte,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  status,
	output logic signed [htfd_pkg::VALUE_W-1:0]   measured_value
);
	import htfd_pkg::*;

	logic               valid_s1, valid_s2;
	logic               kind_s1;
	logic [BYTE_W-1:0]  msb_s1, lsb_s1, chk_s1;
	logic [BYTE_W-1:0]  crc_hi, crc_full;
	logic               status_s2;
	logic signed [VALUE_W-1:0] value_s2;
	logic signed [VALUE_W-1:0] value;
	logic               adv_s2, adv_s1;
	logic               crc_bad;

	htfd_crc_step u_crc_hi (
		.crc_in  ('0),
		.data    (msb_s1),
		.crc_out (crc_hi)
	);

	htfd_crc_step u_crc_lo (
		.crc_in  (crc_hi),
		.data    (lsb_s1),
		.crc_out (crc_full)
	);

	htfd_convert u_convert (
		.kind  (kind_s1),
		.raw   ({msb_s1, lsb_s1} & RAW_MASK),
		.value (value)
	);

	assign crc_bad = (crc_full != chk_s1);

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			kind_s1   <= req_type;
			msb_s1    <= data_msb;
			lsb_s1    <= data_lsb;
			chk_s1    <= check_byte;
		end
		if (adv_s2 && valid_s1) begin
			// Drop the value on a CRC mismatch.
			status_s2 <= crc_bad ? ST_CRC_ERR : ST_OK;
			value_s2  <= crc_bad ? '0 : value;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = status_s2;
	assign measured_value = value_s2;

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("stage 1 item not passed to result register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |=> valid_s1)
		else $error("stage 1 item lost during output stall");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == ST_CRC_ERR |-> value_s2 == '0)
		else $error("CRC error result carries a non-zero value");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled while result register is empty");

endmodule

`default_nettype wire
